// ===== src/vrt_pkg.sv =====
// voxel ray traversal package: number formats, result codes, saturation helper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vrt_pkg;
   localparam int FRAC_BITS = 16;
   // dividend width of the shared divider: b * S with b up to 2^F and S 32 bits
   localparam int DIV_NUM_W = FRAC_BITS + 33;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
   localparam int ORG_EXT_W = FRAC_BITS + 16;

   localparam logic [31:0] INF32 = 32'hFFFF_FFFF;
   localparam logic [23:0] MAX24 = 24'hFF_FFFF;

   localparam logic [1:0] KIND_PROBE = 2'd0;
   localparam logic [1:0] KIND_HIT   = 2'd1;
   localparam logic [1:0] KIND_MISS  = 2'd2;

   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_MINUS = 2'd3;

   localparam logic [2:0] FACE_NONE = 3'd0;

   function automatic logic [31:0] sat32(input logic [DIV_NUM_W-1:0] v);
      logic [31:0] r;
      if (v[DIV_NUM_W-1:32] != '0) r = INF32;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== src/vrt_if.sv =====
// request and response channel interfaces of the voxel ray traversal block
// depends on vrt_pkg only for the file order
`timescale 1ns / 1ps
`default_nettype none
interface vrt_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [23:0]        reach;
   logic [7:0]         probe_type;
   modport source (output valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   reach, probe_type, input ready);
   modport sink (input valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 reach, probe_type, output ready);
endinterface

interface vrt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] cell_x;
   logic signed [15:0] cell_y;
   logic signed [15:0] cell_z;
   logic [2:0]         face;
   logic [23:0]        travel;
   logic [7:0]         hit_type;
   modport source (output valid, kind, cell_x, cell_y, cell_z, face, travel, hit_type,
                   input ready);
   modport sink (input valid, kind, cell_x, cell_y, cell_z, face, travel, hit_type,
                 output ready);
endinterface
`default_nettype wire

// ===== src/vrt_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle
// depends on vrt_pkg
`timescale 1ns / 1ps
`default_nettype none
module vrt_sqrt
   import vrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic [31:0]      root
);
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [33:0] rem_sh;
   logic [33:0] trial;
   logic        fits;

   always_comb begin
      rem_sh = {rem_ff[31:0], rad_ff[63:62]};
      trial  = {root_ff, 2'b01};
      fits   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == 5'd31);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (fits) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

// ===== src/vrt_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on vrt_pkg for the dividend width
`timescale 1ns / 1ps
`default_nettype none
module vrt_div
   import vrt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] dividend,
   input  wire logic [31:0]          divisor,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quotient
);
   logic [DIV_NUM_W-1:0] num_ff;
   logic [31:0]          den_ff;
   logic [31:0]          rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [32:0] rem_sh;
   logic        fits;

   always_comb begin
      rem_sh = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits   = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == DIV_CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            // dividend bits shift out the top, quotient bits fill in below
            if (fits) begin
               rem_ff <= 32'(rem_sh - {1'b0, den_ff});
               num_ff <= {num_ff[DIV_NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[31:0];
               num_ff <= {num_ff[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;
endmodule
`default_nettype wire

// ===== src/voxel_ray_traversal_top.sv =====
// voxel ray traversal top: ray setup sequencer, dda step and result register
// depends on vrt_pkg, vrt_if, vrt_sqrt and vrt_div
`timescale 1ns / 1ps
`default_nettype none
// Walks a ray through a voxel grid one voxel per probe answer. A start beat
// is accepted, then runs length accumulation over the three axes on one
// multiplier, the square root and, per nonzero axis, one setup step and two
// divides on one shared divider (one step per zero axis), then one result
// load. An answer beat that steps is accepted, makes one compare-and-add step
// and ends in a result load; a hit answer goes from accept to the result load.
// The block takes no beat while it works on one; a result waits in an output
// register until the sink takes it.
module voxel_ray_traversal_top
   import vrt_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   vrt_req_if.sink  req_chan,
   vrt_rsp_if.source rsp_chan
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_LEN, ST_SQRT, ST_AXIS, ST_CROSS, ST_BOUND, ST_STEP, ST_EMIT
   } state_type;

   state_type   state_ff;
   logic [1:0]  ax_ff;
   logic [15:0] cell_ff [3];
   logic [1:0]  sign_ff [3];
   logic [31:0] cross_ff [3];
   logic [31:0] bound_ff [3];
   logic [15:0] mag_ff [3];
   logic [FRAC_BITS-1:0] frac_ff [3];
   logic [2:0]  face_ff;
   logic [23:0] travel_ff;
   logic [23:0] reach_ff;
   logic        active_ff;
   logic        hit_ff;
   logic [7:0]  type_ff;
   logic [31:0] len2_ff;
   logic [31:0] root_ff;
   logic [DIV_NUM_W-1:0] prod_ff;

   logic                 sqrt_start_ff;
   logic                 div_start_ff;
   logic [DIV_NUM_W-1:0] div_num_ff;
   logic [31:0]          div_den_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_cell_ff [3];
   logic [2:0]  rsp_face_ff;
   logic [23:0] rsp_travel_ff;
   logic [7:0]  rsp_type_ff;

   logic                 sqrt_done;
   logic [31:0]          sqrt_root;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;

   vrt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand ({len2_ff, 32'd0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   vrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // start beat decode
   logic [15:0] dir_in [3];
   logic [31:0] org_in [3];
   logic [ORG_EXT_W+15:0] org_ext [3];

   always_comb begin
      dir_in[0] = req_chan.dir_x;
      dir_in[1] = req_chan.dir_y;
      dir_in[2] = req_chan.dir_z;
      org_in[0] = req_chan.origin_x;
      org_in[1] = req_chan.origin_y;
      org_in[2] = req_chan.origin_z;
      for (int i = 0; i < 3; i++) begin
         org_ext[i] = {{(ORG_EXT_W - 16){org_in[i][31]}}, org_in[i]};
      end
   end

   // length accumulation and per axis setup arithmetic
   logic [31:0]          sq;
   logic [FRAC_BITS:0]   bdist;
   logic [DIV_NUM_W-1:0] bprod;
   logic                 ax_neg;

   always_comb begin
      sq     = mag_ff[ax_ff] * mag_ff[ax_ff];
      ax_neg = (sign_ff[ax_ff] == SIGN_MINUS);
      if (ax_neg) bdist = {1'b0, frac_ff[ax_ff]};
      else bdist = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac_ff[ax_ff]};
      bprod  = DIV_NUM_W'(bdist) * DIV_NUM_W'(root_ff);
   end

   // dda step: smallest bound, ties to the later axis (z over y over x)
   logic [1:0]  sel;
   logic [31:0] sel_bound;
   logic [32:0] bound_sum;

   always_comb begin
      if (bound_ff[0] < bound_ff[1]) sel = (bound_ff[0] < bound_ff[2]) ? 2'd0 : 2'd2;
      else sel = (bound_ff[1] < bound_ff[2]) ? 2'd1 : 2'd2;
      sel_bound = bound_ff[sel];
      bound_sum = {1'b0, sel_bound} + {1'b0, cross_ff[sel]};
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ax_ff         <= '0;
         active_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         sqrt_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         face_ff       <= FACE_NONE;
         travel_ff     <= '0;
         reach_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            cell_ff[i]  <= '0;
            sign_ff[i]  <= SIGN_NONE;
            cross_ff[i] <= INF32;
            bound_ff[i] <= INF32;
         end
      end else begin
         sqrt_start_ff <= (state_ff == ST_LEN) && (ax_ff == 2'd2);
         div_start_ff  <= ((state_ff == ST_AXIS) && (mag_ff[ax_ff] != '0)) ||
                          ((state_ff == ST_CROSS) && div_done);
         if ((state_ff == ST_EMIT) && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  if (!req_chan.opcode) begin
                     for (int i = 0; i < 3; i++) begin
                        cell_ff[i] <= org_ext[i][FRAC_BITS+15:FRAC_BITS];
                        frac_ff[i] <= org_in[i][FRAC_BITS-1:0];
                        mag_ff[i]  <= dir_in[i][15] ? 16'(~dir_in[i] + 16'd1) : dir_in[i];
                        sign_ff[i] <= (dir_in[i] == '0) ? SIGN_NONE :
                                      (dir_in[i][15] ? SIGN_MINUS : SIGN_PLUS);
                     end
                     face_ff   <= FACE_NONE;
                     travel_ff <= '0;
                     reach_ff  <= req_chan.reach;
                     active_ff <= 1'b1;
                     hit_ff    <= 1'b0;
                     len2_ff   <= '0;
                     ax_ff     <= '0;
                     state_ff  <= ST_LEN;
                  end else if (active_ff) begin
                     if (req_chan.probe_type != 8'd0) begin
                        hit_ff   <= 1'b1;
                        type_ff  <= req_chan.probe_type;
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_STEP;
                     end
                  end
               end
            end
            ST_LEN: begin
               len2_ff <= len2_ff + sq;
               if (ax_ff == 2'd2) begin
                  ax_ff    <= '0;
                  state_ff <= ST_SQRT;
               end else begin
                  ax_ff <= ax_ff + 2'd1;
               end
            end
            ST_SQRT: begin
               if (sqrt_done) begin
                  root_ff  <= sqrt_root;
                  state_ff <= ST_AXIS;
               end
            end
            ST_AXIS: begin
               if (mag_ff[ax_ff] == '0) begin
                  cross_ff[ax_ff] <= INF32;
                  bound_ff[ax_ff] <= INF32;
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= (ax_ff == 2'd2) ? ST_EMIT : ST_AXIS;
               end else begin
                  prod_ff    <= bprod;
                  div_num_ff <= DIV_NUM_W'({root_ff, {FRAC_BITS{1'b0}}});
                  div_den_ff <= {mag_ff[ax_ff], 16'd0};
                  state_ff   <= ST_CROSS;
               end
            end
            ST_CROSS: begin
               if (div_done) begin
                  cross_ff[ax_ff] <= sat32(div_quo);
                  div_num_ff      <= prod_ff;
                  state_ff        <= ST_BOUND;
               end
            end
            ST_BOUND: begin
               if (div_done) begin
                  bound_ff[ax_ff] <= sat32(div_quo);
                  ax_ff    <= ax_ff + 2'd1;
                  state_ff <= (ax_ff == 2'd2) ? ST_EMIT : ST_AXIS;
               end
            end
            ST_STEP: begin
               case (sign_ff[sel])
                  SIGN_PLUS: begin
                     cell_ff[sel] <= cell_ff[sel] + 16'd1;
                     face_ff      <= {sel, 1'b1};
                  end
                  SIGN_MINUS: begin
                     cell_ff[sel] <= cell_ff[sel] - 16'd1;
                     face_ff      <= {sel, 1'b0} + 3'd2;
                  end
                  default: face_ff <= FACE_NONE;
               endcase
               travel_ff     <= (sel_bound > {8'd0, MAX24}) ? MAX24 : sel_bound[23:0];
               bound_ff[sel] <= bound_sum[32] ? INF32 : bound_sum[31:0];
               state_ff      <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_travel_ff <= travel_ff;
                  if (hit_ff) begin
                     rsp_kind_ff <= KIND_HIT;
                     rsp_cell_ff <= cell_ff;
                     rsp_face_ff <= face_ff;
                     rsp_type_ff <= type_ff;
                     active_ff   <= 1'b0;
                     hit_ff      <= 1'b0;
                  end else if (travel_ff < reach_ff) begin
                     rsp_kind_ff <= KIND_PROBE;
                     rsp_cell_ff <= cell_ff;
                     rsp_face_ff <= face_ff;
                     rsp_type_ff <= 8'd0;
                  end else begin
                     rsp_kind_ff <= KIND_MISS;
                     for (int i = 0; i < 3; i++) rsp_cell_ff[i] <= '0;
                     rsp_face_ff <= FACE_NONE;
                     rsp_type_ff <= 8'd0;
                     active_ff   <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.cell_x   = rsp_cell_ff[0];
   assign rsp_chan.cell_y   = rsp_cell_ff[1];
   assign rsp_chan.cell_z   = rsp_cell_ff[2];
   assign rsp_chan.face     = rsp_face_ff;
   assign rsp_chan.travel   = rsp_travel_ff;
   assign rsp_chan.hit_type = rsp_type_ff;
endmodule
`default_nettype wire

// ===== tb/sv/voxel_ray_traversal_top_tb.sv =====
// self-checking testbench for voxel_ray_traversal_top: a queue-fed driver, a
// response monitor and a fixed-point dda tracker that predicts every result
// depends on vrt_pkg, vrt_if and the voxel_ray_traversal_top rtl
`timescale 1ns / 1ps
module voxel_ray_traversal_top_tb;
   import vrt_pkg::*;

   localparam int N_ITEMS = 1150;
   localparam int HOLD_AT = 150;
   localparam int HOLD_CYCLES = 900;
   localparam logic OP_START = 1'b0;
   localparam logic OP_ANSWER = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] ox, oy, oz;
      logic [15:0] dx, dy, dz;
      logic [23:0] reach;
      logic [7:0]  ptype;
   } ray_beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] cx, cy, cz;
      logic [2:0]  face;
      logic [23:0] travel;
      logic [7:0]  htype;
   } trace_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vrt_req_if req_chan();
   vrt_rsp_if rsp_chan();

   voxel_ray_traversal_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   ray_beat_type  beats_pending[$];
   trace_rsp_type rsp_expected[$];
   int errors = 0;
   int taken = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   bit hold_done = 0;
   logic fresh = 1'b0;

   // tracker state
   logic [15:0] t_cell[3];
   logic [1:0]  t_sign[3];
   logic [31:0] t_cross[3];
   logic [31:0] t_bound[3];
   logic [2:0]  t_face;
   logic [23:0] t_travel;
   logic [23:0] t_reach;
   bit          t_active;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n = n - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? INF32 : v[31:0];
   endfunction

   function automatic void tracker_reset();
      for (int i = 0; i < 3; i++) begin
         t_cell[i] = '0;
         t_sign[i] = SIGN_NONE;
         t_cross[i] = INF32;
         t_bound[i] = INF32;
      end
      t_face = FACE_NONE;
      t_travel = '0;
      t_reach = '0;
      t_active = 0;
   endfunction

   function automatic void probe_or_miss();
      trace_rsp_type r;
      r = '0;
      r.travel = t_travel;
      if (t_travel < t_reach) begin
         r.kind = KIND_PROBE;
         r.cx = t_cell[0];
         r.cy = t_cell[1];
         r.cz = t_cell[2];
         r.face = t_face;
      end else begin
         t_active = 0;
         r.kind = KIND_MISS;
      end
      rsp_expected.push_back(r);
   endfunction

   function automatic void track_beat(input ray_beat_type bt);
      logic [31:0] org[3];
      logic [15:0] dir[3];
      logic [63:0] mag[3];
      logic [63:0] l2, s, den, b, sum;
      int ax;
      trace_rsp_type r;
      org[0] = bt.ox; org[1] = bt.oy; org[2] = bt.oz;
      dir[0] = bt.dx; dir[1] = bt.dy; dir[2] = bt.dz;
      if (bt.op == OP_START) begin
         l2 = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = dir[i][15] ? (64'h10000 - {48'd0, dir[i]}) : {48'd0, dir[i]};
            l2 = l2 + mag[i] * mag[i];
         end
         s = int_sqrt(l2 << 32);
         for (int i = 0; i < 3; i++) begin
            t_cell[i] = org[i][31:16];
            if (mag[i] == 0) begin
               t_sign[i] = SIGN_NONE;
               t_cross[i] = INF32;
               t_bound[i] = INF32;
            end else begin
               den = mag[i] << 16;
               b = dir[i][15] ? {48'd0, org[i][15:0]} : (64'h10000 - {48'd0, org[i][15:0]});
               t_sign[i] = dir[i][15] ? SIGN_MINUS : SIGN_PLUS;
               t_cross[i] = clamp32((s << 16) / den);
               t_bound[i] = clamp32((b * s) / den);
            end
         end
         t_face = FACE_NONE;
         t_travel = '0;
         t_reach = bt.reach;
         t_active = 1;
         probe_or_miss();
         return;
      end
      if (!t_active) return;
      if (bt.ptype != 0) begin
         t_active = 0;
         r.kind = KIND_HIT;
         r.cx = t_cell[0];
         r.cy = t_cell[1];
         r.cz = t_cell[2];
         r.face = t_face;
         r.travel = t_travel;
         r.htype = bt.ptype;
         rsp_expected.push_back(r);
         return;
      end
      // ties go to the later axis: z over y over x
      if (t_bound[0] < t_bound[1]) ax = (t_bound[0] < t_bound[2]) ? 0 : 2;
      else ax = (t_bound[1] < t_bound[2]) ? 1 : 2;
      if (t_sign[ax] == SIGN_PLUS) begin
         t_cell[ax] = t_cell[ax] + 16'd1;
         t_face = 3'(2 * ax + 1);
      end else if (t_sign[ax] == SIGN_MINUS) begin
         t_cell[ax] = t_cell[ax] - 16'd1;
         t_face = 3'(2 * ax + 2);
      end else begin
         t_face = FACE_NONE;
      end
      t_travel = (t_bound[ax] > {8'd0, MAX24}) ? MAX24 : t_bound[ax][23:0];
      sum = {32'd0, t_bound[ax]} + {32'd0, t_cross[ax]};
      t_bound[ax] = clamp32(sum);
      probe_or_miss();
   endfunction

   function automatic void push_start(input logic [31:0] ox, oy, oz,
                                      input logic [15:0] dx, dy, dz, input logic [23:0] reach);
      ray_beat_type bt;
      bt.op = OP_START;
      bt.ox = ox; bt.oy = oy; bt.oz = oz;
      bt.dx = dx; bt.dy = dy; bt.dz = dz;
      bt.reach = reach;
      bt.ptype = 8'($urandom);
      beats_pending.push_back(bt);
   endfunction

   function automatic void push_answer(input logic [7:0] ptype);
      ray_beat_type bt;
      bt = ray_beat_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      bt.op = OP_ANSWER;
      bt.ptype = ptype;
      beats_pending.push_back(bt);
   endfunction

   function automatic logic [15:0] rand_dir();
      logic [15:0] d;
      case ($urandom_range(0, 9))
         0: d = 16'h0000;
         1: d = 16'h8000;
         2: d = 16'h7FFF;
         3: d = 16'($urandom_range(1, 64));
         default: d = 16'($urandom);
      endcase
      return d;
   endfunction

   function automatic logic [31:0] rand_origin();
      return ($urandom_range(0, 3) == 0) ? $urandom
                                          : 32'($signed(16'($urandom))) <<< 8;
   endfunction

   function automatic logic [23:0] rand_reach();
      case ($urandom_range(0, 9))
         0: return 24'($urandom);
         1: return 24'd0;
         default: return 24'($urandom_range(1, 24 << 16));
      endcase
   endfunction

   function automatic void build_stimulus();
      int n;
      // answer with no ray in flight is dropped
      push_answer(8'd0);
      push_answer(8'd7);
      // zero reach misses at once
      push_start(32'h0001_8000, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 24'd0);
      push_answer(8'd0);
      // zero direction steps onto an infinite bound
      push_start(32'h0003_4000, 32'hFFFE_0000, 32'h0, 16'h0, 16'h0, 16'h0, MAX24);
      push_answer(8'd0);
      // diagonal ties, then a hit
      push_start(32'h0, 32'h0, 32'h0, 16'h4000, 16'h4000, 16'h4000, MAX24);
      push_answer(8'd0);
      push_answer(8'd0);
      push_answer(8'd0);
      push_answer(8'hFF);
      // negative extremes with cell wrap
      push_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000,
                 MAX24);
      push_answer(8'd0);
      push_answer(8'd0);
      push_answer(8'd1);
      // positive extremes, single axis
      push_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h0, 16'h0,
                 24'h03_0000);
      push_answer(8'd0);
      push_answer(8'd0);
      push_answer(8'd0);
      push_answer(8'd0);
      // start during an active ray drops it
      push_start(32'h0000_0001, 32'h0000_FFFF, 32'h0, 16'h0, 16'hC000, 16'h0001, MAX24);
      push_answer(8'd0);
      push_start(32'h0, 32'h0, 32'h0002_0000, 16'h0, 16'h0, 16'hFFFF, 24'h02_0000);
      push_answer(8'd0);
      push_answer(8'd0);
      push_answer(8'd0);
      while (beats_pending.size() < N_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            push_answer(8'($urandom));
         end else begin
            push_start(rand_origin(), rand_origin(), rand_origin(), rand_dir(), rand_dir(),
                       rand_dir(), rand_reach());
            n = $urandom_range(1, 30);
            for (int k = 0; k < n; k++)
               push_answer(($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
         end
      end
   endfunction

   // accept side: predict at the edge where the beat moves
   always @(posedge clock) begin
      fresh <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         track_beat(beats_pending.pop_front());
         taken <= taken + 1;
      end
   end

   // idling phases by progress through the beats
   always @(posedge clock) begin
      case (taken * 4 / N_ITEMS)
         0: begin send_idle_pct <= 0; rsp_stall_pct <= 0; end
         1: begin send_idle_pct <= 65; rsp_stall_pct <= 0; end
         2: begin send_idle_pct <= 0; rsp_stall_pct <= 65; end
         default: begin send_idle_pct <= 26; rsp_stall_pct <= 26; end
      endcase
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || fresh) begin
         if (beats_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            {req_chan.opcode, req_chan.origin_x, req_chan.origin_y, req_chan.origin_z,
             req_chan.dir_x, req_chan.dir_y, req_chan.dir_z, req_chan.reach,
             req_chan.probe_type} <= beats_pending[0];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && taken >= HOLD_AT) begin
         hold_done <= 1;
         hold_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      trace_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_expected.size() == 0) begin
            $error("unexpected result beat kind=%0d", rsp_chan.kind);
            errors++;
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_chan.kind !== want.kind) begin
               $error("kind: expected %0d got %0d", want.kind, rsp_chan.kind); errors++;
            end
            if (rsp_chan.cell_x !== want.cx) begin
               $error("cell_x: expected %h got %h", want.cx, rsp_chan.cell_x); errors++;
            end
            if (rsp_chan.cell_y !== want.cy) begin
               $error("cell_y: expected %h got %h", want.cy, rsp_chan.cell_y); errors++;
            end
            if (rsp_chan.cell_z !== want.cz) begin
               $error("cell_z: expected %h got %h", want.cz, rsp_chan.cell_z); errors++;
            end
            if (rsp_chan.face !== want.face) begin
               $error("face: expected %0d got %0d", want.face, rsp_chan.face); errors++;
            end
            if (rsp_chan.travel !== want.travel) begin
               $error("travel: expected %h got %h", want.travel, rsp_chan.travel); errors++;
            end
            if (rsp_chan.hit_type !== want.htype) begin
               $error("hit_type: expected %h got %h", want.htype, rsp_chan.hit_type);
               errors++;
            end
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_START;
      req_chan.origin_x = '0;
      req_chan.origin_y = '0;
      req_chan.origin_z = '0;
      req_chan.dir_x = '0;
      req_chan.dir_y = '0;
      req_chan.dir_z = '0;
      req_chan.reach = '0;
      req_chan.probe_type = '0;
      rsp_chan.ready = 1'b0;
      tracker_reset();
      build_stimulus();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      while (beats_pending.size() != 0 || rsp_expected.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (errors == 0 && rsp_expected.size() == 0) begin
         $display("voxel_ray_traversal_top_tb: done, clean");
      end else begin
         $display("voxel_ray_traversal_top_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("voxel_ray_traversal_top_tb: done, errors");
      $finish;
   end
endmodule

// ===== files.f =====
src/vrt_pkg.sv
src/vrt_if.sv
src/vrt_sqrt.sv
src/vrt_div.sv
src/voxel_ray_traversal_top.sv
tb/sv/voxel_ray_traversal_top_tb.sv
